>>> rtl/sopc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sopc_pkg
// Shared types and constants of the second-order position compensator.
// ----------------------------------------------------------------------------
package sopc_pkg;

    localparam int SIG_W   = 32;
    localparam int GAIN_W  = 32;
    localparam int CFGU_W  = 31;
    localparam int PROD_W  = 64;
    localparam int ACC_W   = 59;
    localparam int POS_W   = 40;
    localparam int ERRW_W  = 41;
    localparam int DRV_W   = 43;
    localparam int PADDR_W = 5;
    localparam int PDATA_W = 32;

    // Register indexes on the configuration port.
    typedef enum logic [2:0] {
        REG_GAIN_ERROR_NOW     = 3'd0,
        REG_GAIN_COMMAND_LAST  = 3'd1,
        REG_GAIN_ERROR_LAST    = 3'd2,
        REG_GAIN_COMMAND_OLDER = 3'd3,
        REG_GAIN_ERROR_OLDER   = 3'd4,
        REG_POSITION_SCALE     = 3'd5,
        REG_DRIVE_LIMIT        = 3'd6
    } sopc_reg_t;

    localparam logic signed [GAIN_W-1:0] RST_GAIN_ERROR_NOW     = 32'sd1150561157;
    localparam logic signed [GAIN_W-1:0] RST_GAIN_COMMAND_LAST  = 32'sd16810770;
    localparam logic signed [GAIN_W-1:0] RST_GAIN_ERROR_LAST    = -32'sd1910927770;
    localparam logic signed [GAIN_W-1:0] RST_GAIN_COMMAND_OLDER = -32'sd33722;
    localparam logic signed [GAIN_W-1:0] RST_GAIN_ERROR_OLDER   = 32'sd842216243;
    localparam logic [CFGU_W-1:0]        RST_POSITION_SCALE     = 31'd0;
    localparam logic [CFGU_W-1:0]        RST_DRIVE_LIMIT        = 31'd327680;

    // Order in which the five products go through the shared multiplier.
    typedef enum logic [2:0] {
        TERM_CMD_LAST  = 3'd0,
        TERM_ERR_LAST  = 3'd1,
        TERM_CMD_OLDER = 3'd2,
        TERM_ERR_OLDER = 3'd3,
        TERM_ERR_NOW   = 3'd4
    } sopc_term_t;

    typedef struct packed {
        logic [GAIN_W-1:0] gain_error_now;
        logic [GAIN_W-1:0] gain_command_last;
        logic [GAIN_W-1:0] gain_error_last;
        logic [GAIN_W-1:0] gain_command_older;
        logic [GAIN_W-1:0] gain_error_older;
        logic [CFGU_W-1:0] position_scale;
        logic [CFGU_W-1:0] drive_limit;
    } sopc_cfg_t;

    typedef struct packed {
        logic       start;
        logic       mul_en;
        sopc_term_t term;
        logic       acc_last;
        logic       clamp;
    } sopc_cmd_t;

    typedef struct packed {
        logic out_free;
    } sopc_stat_t;

endpackage
`default_nettype wire

>>> rtl/sopc_regs.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sopc_regs
// Configuration register file behind the APB-style port.
// ----------------------------------------------------------------------------
module sopc_regs
    import sopc_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [PDATA_W-1:0] pwdata,
    output logic      [PDATA_W-1:0] prdata,
    output logic                    pready,
    output sopc_cfg_t               cfg
);

    sopc_cfg_t cfg_reg;
    sopc_reg_t index;
    logic      wr_en;

    assign index  = sopc_reg_t'(paddr[PADDR_W-1:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.gain_error_now     <= RST_GAIN_ERROR_NOW;
            cfg_reg.gain_command_last  <= RST_GAIN_COMMAND_LAST;
            cfg_reg.gain_error_last    <= RST_GAIN_ERROR_LAST;
            cfg_reg.gain_command_older <= RST_GAIN_COMMAND_OLDER;
            cfg_reg.gain_error_older   <= RST_GAIN_ERROR_OLDER;
            cfg_reg.position_scale     <= RST_POSITION_SCALE;
            cfg_reg.drive_limit        <= RST_DRIVE_LIMIT;
        end
        else if (wr_en)
        begin
            unique case (index)
                REG_GAIN_ERROR_NOW:     cfg_reg.gain_error_now     <= pwdata;
                REG_GAIN_COMMAND_LAST:  cfg_reg.gain_command_last  <= pwdata;
                REG_GAIN_ERROR_LAST:    cfg_reg.gain_error_last    <= pwdata;
                REG_GAIN_COMMAND_OLDER: cfg_reg.gain_command_older <= pwdata;
                REG_GAIN_ERROR_OLDER:   cfg_reg.gain_error_older   <= pwdata;
                REG_POSITION_SCALE:     cfg_reg.position_scale     <= pwdata[CFGU_W-1:0];
                REG_DRIVE_LIMIT:        cfg_reg.drive_limit        <= pwdata[CFGU_W-1:0];
                default:                ;
            endcase
        end
    end

    always_comb
    begin
        unique case (index)
            REG_GAIN_ERROR_NOW:     prdata = cfg_reg.gain_error_now;
            REG_GAIN_COMMAND_LAST:  prdata = cfg_reg.gain_command_last;
            REG_GAIN_ERROR_LAST:    prdata = cfg_reg.gain_error_last;
            REG_GAIN_COMMAND_OLDER: prdata = cfg_reg.gain_command_older;
            REG_GAIN_ERROR_OLDER:   prdata = cfg_reg.gain_error_older;
            REG_POSITION_SCALE:     prdata = {1'b0, cfg_reg.position_scale};
            REG_DRIVE_LIMIT:        prdata = {1'b0, cfg_reg.drive_limit};
            default:                prdata = '0;
        endcase
    end

endmodule
`default_nettype wire

>>> rtl/sopc_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sopc_ctrl
// Sequencer that steps the shared multiplier through the five products.
// ----------------------------------------------------------------------------
module sopc_ctrl
    import sopc_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  sopc_stat_t      stat,
    output sopc_cmd_t       cmd
);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_MUL   = 4'b0010,
        ST_LAST  = 4'b0100,
        ST_CLAMP = 4'b1000
    } state_t;

    state_t     state_reg, state_next;
    sopc_term_t term_reg, term_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            term_reg  <= TERM_CMD_LAST;
        end
        else
        begin
            state_reg <= state_next;
            term_reg  <= term_next;
        end
    end

    assign in_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next   = state_reg;
        term_next    = term_reg;
        cmd.start    = 1'b0;
        cmd.mul_en   = 1'b0;
        cmd.term     = term_reg;
        cmd.acc_last = 1'b0;
        cmd.clamp    = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd.start = in_valid;
                term_next = TERM_CMD_LAST;
                if (in_valid)
                begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                cmd.mul_en = 1'b1;
                if (term_reg == TERM_ERR_NOW)
                begin
                    state_next = ST_LAST;
                end
                else
                begin
                    term_next = sopc_term_t'(term_reg + 3'd1);
                end
            end
            ST_LAST:
            begin
                cmd.acc_last = 1'b1;
                state_next   = ST_CLAMP;
            end
            ST_CLAMP:
            begin
                // The result leaves only when the output register can take it.
                cmd.clamp = stat.out_free;
                if (stat.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

>>> rtl/sopc_dp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sopc_dp
// Datapath: shared 32x32 multiplier, error, accumulator, clamp, history.
// ----------------------------------------------------------------------------
module sopc_dp
    import sopc_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  sopc_cfg_t                    cfg,
    input  sopc_cmd_t                    cmd,
    output sopc_stat_t                   stat,
    input  wire logic signed [SIG_W-1:0] setpoint,
    input  wire logic signed [SIG_W-1:0] position_rev,
    output logic             [SIG_W-1:0] drive,
    output logic                         saturated,
    output logic                         out_valid,
    input  wire logic                    out_ready
);

    logic signed [SIG_W-1:0]  setpoint_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [SIG_W-1:0]  err_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [SIG_W-1:0]  cmd_last_reg, cmd_older_reg, err_last_reg, err_older_reg;
    logic        [SIG_W-1:0]  drive_reg;
    logic                     sat_reg;
    logic                     out_valid_reg;

    logic signed [SIG_W-1:0]  mul_a, mul_b;
    logic signed [PROD_W-1:0] mul_p;
    logic signed [PROD_W-1:0] pos_rnd;
    logic signed [POS_W-1:0]  pos;
    logic signed [ERRW_W-1:0] err_wide;
    logic signed [SIG_W-1:0]  err_sat;
    logic signed [ACC_W-1:0]  acc_term;
    logic signed [ACC_W-1:0]  acc_rnd;
    logic signed [DRV_W-1:0]  drv_raw, lim_pos, lim_neg;
    logic signed [SIG_W-1:0]  drv_clamped;
    logic                     drv_sat;
    logic                     out_free;

    // Operand select for the shared multiplier.
    always_comb
    begin
        if (cmd.start)
        begin
            mul_a = position_rev;
            mul_b = $signed({1'b0, cfg.position_scale});
        end
        else
        begin
            case (cmd.term)
                TERM_CMD_LAST:
                begin
                    mul_a = $signed(cfg.gain_command_last);
                    mul_b = cmd_last_reg;
                end
                TERM_ERR_LAST:
                begin
                    mul_a = $signed(cfg.gain_error_last);
                    mul_b = err_last_reg;
                end
                TERM_CMD_OLDER:
                begin
                    mul_a = $signed(cfg.gain_command_older);
                    mul_b = cmd_older_reg;
                end
                TERM_ERR_OLDER:
                begin
                    mul_a = $signed(cfg.gain_error_older);
                    mul_b = err_older_reg;
                end
                default:
                begin
                    mul_a = $signed(cfg.gain_error_now);
                    mul_b = err_reg;
                end
            endcase
        end
    end

    assign mul_p = mul_a * mul_b;

    // Position rounds half up from Q24.40 to Q16.16; the error saturates to 32 bits.
    assign pos_rnd  = prod_reg + 64'sd8388608;
    assign pos      = pos_rnd[PROD_W-1:24];
    assign err_wide = ERRW_W'(setpoint_reg) - ERRW_W'(pos);

    always_comb
    begin
        if (err_wide > 41'sd2147483647)
        begin
            err_sat = 32'sh7fffffff;
        end
        else if (err_wide < -41'sd2147483648)
        begin
            err_sat = 32'sh80000000;
        end
        else
        begin
            err_sat = err_wide[SIG_W-1:0];
        end
    end

    assign acc_term = ACC_W'($signed(prod_reg[PROD_W-1:8]));

    // Final rounding from Q27.32 to Q16.16 and the symmetric clamp.
    assign acc_rnd = acc_reg + 59'sd32768;
    assign drv_raw = acc_rnd[ACC_W-1:16];
    assign lim_pos = $signed({{(DRV_W-CFGU_W){1'b0}}, cfg.drive_limit});
    assign lim_neg = -lim_pos;

    always_comb
    begin
        if (drv_raw > lim_pos)
        begin
            drv_clamped = lim_pos[SIG_W-1:0];
            drv_sat     = 1'b1;
        end
        else if (drv_raw < lim_neg)
        begin
            drv_clamped = lim_neg[SIG_W-1:0];
            drv_sat     = 1'b1;
        end
        else
        begin
            drv_clamped = drv_raw[SIG_W-1:0];
            drv_sat     = 1'b0;
        end
    end

    assign out_free      = !out_valid_reg || out_ready;
    assign stat.out_free = out_free;

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            setpoint_reg <= setpoint;
        end
        if (cmd.start || cmd.mul_en)
        begin
            prod_reg <= mul_p;
        end
        if (cmd.mul_en)
        begin
            if (cmd.term == TERM_CMD_LAST)
            begin
                // The product register still holds the scaled position here.
                err_reg <= err_sat;
                acc_reg <= '0;
            end
            else
            begin
                acc_reg <= acc_reg + acc_term;
            end
        end
        else if (cmd.acc_last)
        begin
            acc_reg <= acc_reg + acc_term;
        end
        if (cmd.clamp)
        begin
            drive_reg <= drv_clamped;
            sat_reg   <= drv_sat;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_last_reg  <= '0;
            cmd_older_reg <= '0;
            err_last_reg  <= '0;
            err_older_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.clamp)
            begin
                cmd_older_reg <= cmd_last_reg;
                err_older_reg <= err_last_reg;
                cmd_last_reg  <= drv_clamped;
                err_last_reg  <= err_reg;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign drive     = drive_reg;
    assign saturated = sat_reg;
    assign out_valid = out_valid_reg;

endmodule
`default_nettype wire

>>> rtl/second_order_position_compensator_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// second_order_position_compensator_unit
// Discrete second-order compensator with output clamp, Q16.16 signals.
// ----------------------------------------------------------------------------
// Usage:
// Each control tick enters as one item on the s_ side: setpoint and
// measured rotary position. One item leaves on the m_ side with the clamped
// drive command in tdata and the saturation flag in tuser.
// An item is accepted only while no other item is in progress: one shared
// 32x32 multiplier forms the scaled position and then the five gain
// products, one per cycle, while the accumulator adds the previous product.
// A result waits in the output register while the receiver stalls; the next
// item is accepted and worked on meanwhile, and it only stops at the clamp
// step until the output register is free.
// Reset clears the error and command history to zero and loads the default
// gains, a zero position scale and a drive limit of 5.0.
// Configuration is written through the APB-style port between items.
// ----------------------------------------------------------------------------
module second_order_position_compensator_unit
    import sopc_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    input  wire logic [63:0]        s_tdata,   // setpoint [31:0], position_rev [63:32]
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    output logic      [31:0]        m_tdata,   // drive [31:0]
    output logic      [0:0]         m_tuser,   // saturated [0]
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [PDATA_W-1:0] pwdata,
    output logic      [PDATA_W-1:0] prdata,
    output logic                    pready
);

    sopc_cfg_t  cfg;
    sopc_cmd_t  cmd;
    sopc_stat_t stat;
    logic       sat;

    sopc_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    sopc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    sopc_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .cmd          (cmd),
        .stat         (stat),
        .setpoint     (s_tdata[31:0]),
        .position_rev (s_tdata[63:32]),
        .drive        (m_tdata),
        .saturated    (sat),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready)
    );

    assign m_tuser[0] = sat;

    // A flagged result sits exactly on one of the two bounds.
    a_sat_on_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[0]) |->
        ($signed(m_tdata) == $signed({1'b0, cfg.drive_limit})
         || $signed(m_tdata) == -$signed({1'b0, cfg.drive_limit})))
        else $error("saturated result is not on a bound");

    // An unflagged result lies within the bounds.
    a_unsat_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser[0]) |->
        ($signed(m_tdata) <= $signed({1'b0, cfg.drive_limit})
         && $signed(m_tdata) >= -$signed({1'b0, cfg.drive_limit})))
        else $error("unsaturated result exceeds the limit");

    // One item at a time: no acceptance in the cycle after an acceptance.
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input accepted while an item is in progress");

endmodule
`default_nettype wire

>>> tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the second-order position compensator.
// Control ticks go in on the s_ stream and drive commands come back on the
// m_ stream. A bit-true model of the compensator inside the bench predicts
// each drive and saturation flag, and every returned item is compared with
// the oldest prediction. Gains, scale and limit are rewritten over the APB
// port between phases while the pipeline is empty. Both stream sides
// insert random gaps, with some phases running at full rate.
// ----------------------------------------------------------------------------
module tb_top;
    import sopc_pkg::*;

    // Index with no register behind it; writes there must be ignored.
    localparam logic [2:0] REG_UNMAPPED = 3'd7;

    localparam longint POS_ROUND = 64'sd8388608;
    localparam longint DRV_ROUND = 64'sd32768;
    localparam longint ERR_MAX   = 64'sd2147483647;
    localparam longint ERR_MIN   = -64'sd2147483648;

    typedef struct {
        logic [31:0] drive;
        logic        saturated;
    } drive_result_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               s_tvalid = 1'b0;
    wire                s_tready;
    logic [63:0]        s_tdata = '0;     // setpoint [31:0], position_rev [63:32]
    wire                m_tvalid;
    logic               m_tready = 1'b0;
    wire  [31:0]        m_tdata;          // drive [31:0]
    wire  [0:0]         m_tuser;          // saturated [0]
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [PDATA_W-1:0] pwdata = '0;
    wire  [PDATA_W-1:0] prdata;
    wire                pready;

    // Bench copy of the configuration and the history registers.
    sopc_cfg_t          coef;
    logic signed [31:0] cmd_z1, cmd_z2, err_z1, err_z2;

    drive_result_t      pending_drives[$];
    int                 mismatch_count = 0;
    bit                 no_stall = 1'b0;

    second_order_position_compensator_unit i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #1 clk = ~clk;

    initial
    begin
        #2000000;
        $display("tb_top: FAIL");
        $finish;
    end

    function automatic drive_result_t predict_drive(input logic signed [31:0] sp,
                                                    input logic signed [31:0] pr);
        longint        scaled;
        longint        err;
        longint        acc;
        longint        drv;
        longint        lim;
        drive_result_t res;
        scaled = (longint'(pr) * longint'(coef.position_scale) + POS_ROUND) >>> 24;
        err = longint'(sp) - scaled;
        if (err > ERR_MAX)
            err = ERR_MAX;
        if (err < ERR_MIN)
            err = ERR_MIN;
        acc = ((longint'($signed(coef.gain_error_now)) * err) >>> 8)
            + ((longint'($signed(coef.gain_command_last)) * longint'(cmd_z1)) >>> 8)
            + ((longint'($signed(coef.gain_error_last)) * longint'(err_z1)) >>> 8)
            + ((longint'($signed(coef.gain_command_older)) * longint'(cmd_z2)) >>> 8)
            + ((longint'($signed(coef.gain_error_older)) * longint'(err_z2)) >>> 8);
        drv = (acc + DRV_ROUND) >>> 16;
        lim = longint'(coef.drive_limit);
        res.saturated = 1'b0;
        if (drv > lim)
        begin
            drv = lim;
            res.saturated = 1'b1;
        end
        else if (drv < -lim)
        begin
            drv = -lim;
            res.saturated = 1'b1;
        end
        cmd_z2 = cmd_z1;
        err_z2 = err_z1;
        cmd_z1 = drv[31:0];
        err_z1 = err[31:0];
        res.drive = drv[31:0];
        return res;
    endfunction

    function automatic logic [31:0] rand_signal();
        logic [31:0] v;
        v = $urandom();
        case ($urandom_range(0, 5))
            0, 1: return v;
            2, 3: return {{14{v[17]}}, v[17:0]};
            4: return {{8{v[23]}}, v[23:0]};
            default:
            begin
                case (v[2:0])
                    3'd0: return 32'h8000_0000;
                    3'd1: return 32'h7FFF_FFFF;
                    3'd2: return 32'hFFFF_FFFF;
                    3'd3: return 32'h0000_0001;
                    default: return 32'h0000_0000;
                endcase
            end
        endcase
    endfunction

    function automatic logic [31:0] rand_gain();
        logic [31:0] v;
        v = $urandom();
        return {{6{v[25]}}, v[25:0]};
    endfunction

    task automatic write_reg(input logic [2:0] index, input logic [31:0] value);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {index, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(negedge clk); while (pready !== 1'b1);
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        case (index)
            REG_GAIN_ERROR_NOW:     coef.gain_error_now     = value;
            REG_GAIN_COMMAND_LAST:  coef.gain_command_last  = value;
            REG_GAIN_ERROR_LAST:    coef.gain_error_last    = value;
            REG_GAIN_COMMAND_OLDER: coef.gain_command_older = value;
            REG_GAIN_ERROR_OLDER:   coef.gain_error_older   = value;
            REG_POSITION_SCALE:     coef.position_scale     = value[CFGU_W-1:0];
            REG_DRIVE_LIMIT:        coef.drive_limit        = value[CFGU_W-1:0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic load_coefs(input logic [31:0] e0, input logic [31:0] u1,
                              input logic [31:0] e1, input logic [31:0] u2,
                              input logic [31:0] e2, input logic [31:0] scale,
                              input logic [31:0] limit);
        write_reg(REG_GAIN_ERROR_NOW, e0);
        write_reg(REG_GAIN_COMMAND_LAST, u1);
        write_reg(REG_GAIN_ERROR_LAST, e1);
        write_reg(REG_GAIN_COMMAND_OLDER, u2);
        write_reg(REG_GAIN_ERROR_OLDER, e2);
        write_reg(REG_POSITION_SCALE, scale);
        write_reg(REG_DRIVE_LIMIT, limit);
    endtask

    // Returns at the edge where the item was taken, with tvalid still high, so
    // that a following item with no gap keeps tvalid up without a glitch.
    task automatic send_tick(input logic signed [31:0] sp, input logic signed [31:0] pr);
        int gap;
        gap = no_stall ? 0 : $urandom_range(0, 8);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {pr, sp};
        do @(negedge clk); while (s_tready !== 1'b1);
        @(posedge clk);
        pending_drives.push_back(predict_drive(sp, pr));
    endtask

    task automatic drain_pipeline();
        s_tvalid <= 1'b0;
        while (pending_drives.size() != 0)
            @(posedge clk);
    endtask

    task automatic report_mismatch(input string what, input drive_result_t want,
                                   input logic [31:0] got_drive, input logic got_sat);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("%t %s: expected drive %h sat %b, got drive %h sat %b",
                     $realtime, what, want.drive, want.saturated, got_drive, got_sat);
    endtask

    initial
    begin : result_monitor
        int            stall;
        logic [31:0]   got_drive;
        logic          got_sat;
        drive_result_t want;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            stall = no_stall ? 0 : $urandom_range(0, 8);
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(negedge clk); while (m_tvalid !== 1'b1);
            got_drive = m_tdata;
            got_sat   = m_tuser[0];
            @(posedge clk);
            if (pending_drives.size() == 0)
            begin
                want.drive = 'x;
                want.saturated = 1'bx;
                report_mismatch("unexpected item", want, got_drive, got_sat);
            end
            else
            begin
                want = pending_drives.pop_front();
                if (want.drive !== got_drive || want.saturated !== got_sat)
                    report_mismatch("drive mismatch", want, got_drive, got_sat);
            end
        end
    end

    // Reset gains with zero scale: the error is the setpoint alone.
    task automatic test_default_zero_scale();
        send_tick(32'sh0000_0000, 32'sh0000_0000);
        send_tick(32'sh7FFF_FFFF, 32'sh8000_0000);
        send_tick(32'sh8000_0000, 32'sh7FFF_FFFF);
        send_tick(32'sh0000_0001, 32'shFFFF_FFFF);
        send_tick(32'shFFFF_FFFF, 32'sh0000_0001);
        drain_pipeline();
    endtask

    // Largest scale with opposite extremes drives the error past 32 bits.
    // The scale write carries a set top bit, which the 31-bit register drops.
    task automatic test_error_overflow();
        write_reg(REG_UNMAPPED, $urandom());
        write_reg(REG_POSITION_SCALE, 32'hFFFF_FFFF);
        write_reg(REG_DRIVE_LIMIT, 32'hFFFF_FFFF);
        send_tick(32'sh7FFF_FFFF, 32'sh8000_0000);
        send_tick(32'sh8000_0000, 32'sh7FFF_FFFF);
        send_tick(32'sh0000_0000, 32'sh0000_0000);
        send_tick(32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
        drain_pipeline();
    endtask

    // A unit gain on the current error only makes drive equal the setpoint,
    // so the clamp can be hit exactly at and just past each bound.
    task automatic test_clamp_bounds();
        load_coefs(32'h0100_0000, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'd1000);
        send_tick(32'sd1000, 32'sd0);
        send_tick(32'sd1001, 32'sd0);
        send_tick(-32'sd1000, 32'sd0);
        send_tick(-32'sd1001, 32'sd0);
        send_tick(32'sd0, 32'sd0);
        drain_pipeline();
    endtask

    // With a zero limit the drive stays at zero and only a nonzero sum flags.
    task automatic test_zero_limit();
        load_coefs(RST_GAIN_ERROR_NOW, RST_GAIN_COMMAND_LAST, RST_GAIN_ERROR_LAST,
                   RST_GAIN_COMMAND_OLDER, RST_GAIN_ERROR_OLDER, 32'h0, 32'h0);
        send_tick(32'sd0, 32'sd0);
        send_tick(32'sd0, 32'sd0);
        send_tick(32'sd0, 32'sd0);
        send_tick(32'sd655, 32'sd0);
        send_tick(-32'sd655, 32'sd0);
        drain_pipeline();
    endtask

    task automatic test_random_phases();
        int          ph;
        int          n;
        logic [31:0] lim;
        for (ph = 0; ph < 10; ph++)
        begin
            no_stall = (ph % 4 == 3);
            case ($urandom_range(0, 3))
                0: lim = 32'h0;
                1: lim = $urandom();
                2: lim = 32'h7FFF_FFFF;
                default: lim = $urandom_range(0, 32'h0010_0000);
            endcase
            case (ph % 5)
                0: load_coefs(RST_GAIN_ERROR_NOW, RST_GAIN_COMMAND_LAST,
                              RST_GAIN_ERROR_LAST, RST_GAIN_COMMAND_OLDER,
                              RST_GAIN_ERROR_OLDER, 32'd1677722 + $urandom_range(0, 65535),
                              RST_DRIVE_LIMIT);
                1: load_coefs($urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
                              $urandom(), lim);
                2: load_coefs(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                              32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
                3: load_coefs(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                              32'h8000_0000, 32'h0, 32'h0);
                default: load_coefs(rand_gain(), rand_gain(), rand_gain(), rand_gain(),
                                    rand_gain(), $urandom_range(0, 32'h0400_0000),
                                    32'h7FFF_FFFF);
            endcase
            for (n = 0; n < 125; n++)
                send_tick(rand_signal(), rand_signal());
            drain_pipeline();
        end
        no_stall = 1'b0;
    endtask

    initial
    begin
        coef.gain_error_now     = RST_GAIN_ERROR_NOW;
        coef.gain_command_last  = RST_GAIN_COMMAND_LAST;
        coef.gain_error_last    = RST_GAIN_ERROR_LAST;
        coef.gain_command_older = RST_GAIN_COMMAND_OLDER;
        coef.gain_error_older   = RST_GAIN_ERROR_OLDER;
        coef.position_scale     = RST_POSITION_SCALE;
        coef.drive_limit        = RST_DRIVE_LIMIT;
        cmd_z1 = '0;
        cmd_z2 = '0;
        err_z1 = '0;
        err_z2 = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_default_zero_scale();
        test_error_overflow();
        test_clamp_bounds();
        test_zero_limit();
        test_random_phases();

        repeat (16) @(posedge clk);
        if (mismatch_count == 0 && pending_drives.size() == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule
